[hw/rtl/aeag_pkg.sv]
// Shared types and constants for the array element address generator.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package aeag_pkg;

	localparam int DEF_MAX_ARRAYS = 16;
	localparam int DEF_MAX_DIMS   = 10;

	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;

	localparam int Q_DEPTH = 2;
	localparam int Q_PW    = 1;

	localparam logic [1:0] CMD_HEADER = 2'd0;
	localparam logic [1:0] CMD_BOUNDS = 2'd1;
	localparam logic [1:0] CMD_INDEX  = 2'd2;

	typedef enum logic [1:0] {
		OP_HEADER,
		OP_BOUNDS,
		OP_INDEX
	} aeag_op_t;

	typedef enum logic [1:0] {
		ST_FETCH,
		ST_EXEC,
		ST_SCALE
	} aeag_state_t;

	typedef struct packed {
		aeag_op_t    op;
		logic [3:0]  array_id;
		logic [3:0]  dim_pos;
		logic [3:0]  dim_total;
		logic [31:0] value_a;
		logic [31:0] value_b;
	} aeag_entry_t;

endpackage

[hw/rtl/aeag_front.sv]
// Front end: accepts input requests, decodes the command and drops invalid ones.
// Depends on aeag_pkg; feeds aeag_queue.
`timescale 1ns / 1ps

module aeag_front #(
	parameter int MAX_ARRAYS = aeag_pkg::DEF_MAX_ARRAYS,
	parameter int MAX_DIMS   = aeag_pkg::DEF_MAX_DIMS
) (
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// array_id, dim_pos, dim_total, value_a, value_b, zero pad
	input  logic [aeag_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// command
	input  logic [aeag_pkg::S_TUSER_W-1:0]      s_axis_tuser,
	input  logic                                q_full,
	output logic                                push_valid,
	output aeag_pkg::aeag_entry_t               push_entry
);
	import aeag_pkg::*;

	logic       keep;
	logic       id_ok;
	logic       pos_ok;
	logic [1:0] cmd;

	assign cmd    = s_axis_tuser[1:0];
	assign id_ok  = 32'(s_axis_tdata[3:0]) < 32'(MAX_ARRAYS);
	assign pos_ok = 32'(s_axis_tdata[7:4]) < 32'(MAX_DIMS);

	always_comb begin
		push_entry.array_id  = s_axis_tdata[3:0];
		push_entry.dim_pos   = s_axis_tdata[7:4];
		push_entry.dim_total = s_axis_tdata[11:8];
		push_entry.value_a   = s_axis_tdata[43:12];
		push_entry.value_b   = s_axis_tdata[75:44];
		push_entry.op        = OP_HEADER;
		keep                 = 1'b0;
		case (cmd)
			CMD_HEADER: begin
				push_entry.op = OP_HEADER;
				keep          = id_ok;
			end
			CMD_BOUNDS: begin
				push_entry.op = OP_BOUNDS;
				keep          = id_ok && pos_ok;
			end
			CMD_INDEX: begin
				push_entry.op = OP_INDEX;
				keep          = id_ok;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped requests are still taken from the bus
	assign s_axis_tready = !q_full;
	assign push_valid    = s_axis_tvalid && !q_full && keep;

endmodule

[hw/rtl/aeag_queue.sv]
// Short request queue between front end and back end.
// Depends on aeag_pkg.
`timescale 1ns / 1ps

module aeag_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  aeag_pkg::aeag_entry_t push_entry,
	output logic                  full,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output aeag_pkg::aeag_entry_t pop_entry
);
	import aeag_pkg::*;

	aeag_entry_t       slot_q [Q_DEPTH];
	logic [Q_PW-1:0]   wr_ptr_q;
	logic [Q_PW-1:0]   rd_ptr_q;
	logic [Q_PW:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == (Q_PW+1)'(Q_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = slot_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

[hw/rtl/aeag_back.sv]
// Back end: descriptor memories, Horner accumulator and address scaling.
// Depends on aeag_pkg; drains aeag_queue and drives the output register.
`timescale 1ns / 1ps

module aeag_back #(
	parameter int MAX_ARRAYS = aeag_pkg::DEF_MAX_ARRAYS,
	parameter int MAX_DIMS   = aeag_pkg::DEF_MAX_DIMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  aeag_pkg::aeag_entry_t pop_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           address,
	output logic [3:0]            ref_array
);
	import aeag_pkg::*;

	localparam int AW     = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
	localparam int BDEPTH = MAX_ARRAYS * MAX_DIMS;
	localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int PW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	// header: count, size, base
	logic [67:0]  hdr_mem [MAX_ARRAYS];
	// bounds: upper, lower
	logic [63:0]  bnd_mem [BDEPTH];
	logic [67:0]  hdr_rd_q;
	logic [63:0]  bnd_rd_q;

	aeag_state_t  state_q;
	aeag_state_t  state_d;
	logic [31:0]  acc_q;
	logic [PW-1:0] pos_q;
	logic [31:0]  va_q;
	logic [3:0]   id_q;
	logic [31:0]  prod_q;
	logic         out_valid_q;
	logic [31:0]  address_q;
	logic [3:0]   ref_array_q;

	logic         hdr_we;
	logic         bnd_we;
	logic         rd_en;
	logic         acc_ld;
	logic         fire;
	logic         out_free;
	logic [31:0]  id_wide;
	logic [AW-1:0] hdr_idx;
	logic [31:0]  row_sum;
	logic [BAW-1:0] bnd_addr;
	logic [31:0]  lo;
	logic [31:0]  ext;
	logic [31:0]  acc_next;
	logic [3:0]   cnt;
	logic [4:0]   cnt_eff;
	logic         last;

	assign id_wide  = 32'(pop_entry.array_id);
	assign hdr_idx  = id_wide[AW-1:0];
	assign row_sum  = id_wide * 32'(MAX_DIMS) +
		((pop_entry.op == OP_BOUNDS) ? 32'(pop_entry.dim_pos) : 32'(pos_q));
	assign bnd_addr = row_sum[BAW-1:0];

	always_ff @(posedge clk) begin
		if (hdr_we) hdr_mem[hdr_idx] <= {pop_entry.dim_total, pop_entry.value_b,
			pop_entry.value_a};
		if (bnd_we) bnd_mem[bnd_addr] <= {pop_entry.value_b, pop_entry.value_a};
		if (rd_en) begin
			hdr_rd_q <= hdr_mem[hdr_idx];
			bnd_rd_q <= bnd_mem[bnd_addr];
			va_q     <= pop_entry.value_a;
			id_q     <= pop_entry.array_id;
		end
	end

	assign lo       = bnd_rd_q[31:0];
	assign ext      = bnd_rd_q[63:32] - lo + 32'd1;
	assign acc_next = acc_q * ext + (va_q - lo);
	assign cnt      = hdr_rd_q[67:64];

	always_comb begin
		if (cnt == 4'd0) begin
			cnt_eff = 5'd1;
		end else if (32'(cnt) > 32'(MAX_DIMS)) begin
			cnt_eff = 5'(MAX_DIMS);
		end else begin
			cnt_eff = {1'b0, cnt};
		end
	end

	assign last     = (5'(pos_q) + 5'd1) >= cnt_eff;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		hdr_we    = 1'b0;
		bnd_we    = 1'b0;
		rd_en     = 1'b0;
		acc_ld    = 1'b0;
		fire      = 1'b0;
		case (state_q)
			ST_FETCH: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					case (pop_entry.op)
						OP_HEADER: hdr_we = 1'b1;
						OP_BOUNDS: bnd_we = 1'b1;
						OP_INDEX: begin
							rd_en   = 1'b1;
							state_d = ST_EXEC;
						end
						default: ;
					endcase
				end
			end
			ST_EXEC: begin
				acc_ld  = 1'b1;
				state_d = last ? ST_SCALE : ST_FETCH;
			end
			ST_SCALE: begin
				if (out_free) begin
					fire    = 1'b1;
					state_d = ST_FETCH;
				end
			end
			default: begin
				state_d = ST_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_ld) begin
				if (last) begin
					acc_q <= '0;
					pos_q <= '0;
				end else begin
					acc_q <= acc_next;
					pos_q <= pos_q + 1'b1;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_ld && last) prod_q <= acc_next;
		if (fire) begin
			address_q   <= hdr_rd_q[31:0] + hdr_rd_q[63:32] * prod_q;
			ref_array_q <= id_q;
		end
	end

	assign out_valid = out_valid_q;
	assign address   = address_q;
	assign ref_array = ref_array_q;

endmodule

[hw/rtl/array_element_address_generator.sv]
// Array element address generator, top level.
// From the last index request to m_axis_tvalid: queue slot, descriptor read registers, prod_q,
// output register. Header and bound writes end in ST_FETCH; index requests also pass ST_EXEC,
// the closing one also ST_SCALE: the Horner multiply-add and the size multiply run in series.
// Reset (arst_n, asynchronous): clears control, accumulator and position; descriptor
// memories are undefined until written, and no clearing pass is made.
`timescale 1ns / 1ps

module array_element_address_generator #(
	parameter int MAX_ARRAYS = aeag_pkg::DEF_MAX_ARRAYS,
	parameter int MAX_DIMS   = aeag_pkg::DEF_MAX_DIMS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// array_id, dim_pos, dim_total, value_a, value_b, zero pad
	input  logic [aeag_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// command
	input  logic [aeag_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// address, ref_array, zero pad
	output logic [aeag_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import aeag_pkg::*;

	logic        q_full;
	logic        push_valid;
	aeag_entry_t push_entry;
	logic        pop_valid;
	logic        pop_ready;
	aeag_entry_t pop_entry;
	logic [31:0] address;
	logic [3:0]  ref_array;

	aeag_front #(
		.MAX_ARRAYS(MAX_ARRAYS),
		.MAX_DIMS  (MAX_DIMS)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_full       (q_full),
		.push_valid   (push_valid),
		.push_entry   (push_entry)
	);

	aeag_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry)
	);

	aeag_back #(
		.MAX_ARRAYS(MAX_ARRAYS),
		.MAX_DIMS  (MAX_DIMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_entry(pop_entry),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.address  (address),
		.ref_array(ref_array)
	);

	assign m_axis_tdata = {4'd0, ref_array, address};

endmodule

[tb/address_checker.sv]
// Scoreboard for the array element address generator: watches both stream channels,
// predicts each element address from the accepted requests and compares results.
// Depends on aeag_pkg for the request layout and opcodes.
`timescale 1ns / 1ps

module address_checker #(
	parameter int MAX_ARRAYS = aeag_pkg::DEF_MAX_ARRAYS,
	parameter int MAX_DIMS   = aeag_pkg::DEF_MAX_DIMS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	// array_id, dim_pos, dim_total, value_a, value_b, zero pad
	input  logic [aeag_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// command
	input  logic [aeag_pkg::S_TUSER_W-1:0] s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// address, ref_array, zero pad
	input  logic [aeag_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output int                             errors,
	output int                             pending,
	output int                             checked
);
	import aeag_pkg::*;

	typedef struct packed {
		logic [31:0] address;
		logic [3:0]  ref_array;
	} elem_addr_t;

	logic [31:0] base_mem [MAX_ARRAYS];
	logic [31:0] size_mem [MAX_ARRAYS];
	logic [3:0]  dims_mem [MAX_ARRAYS];
	logic [31:0] lower_mem [MAX_ARRAYS][MAX_DIMS];
	logic [31:0] upper_mem [MAX_ARRAYS][MAX_DIMS];
	logic [31:0] horner;
	int          index_pos;

	elem_addr_t  addr_q [$];

	initial begin
		errors  = 0;
		pending = 0;
		checked = 0;
	end

	// Horner-form row-major address: acc = acc*extent + (index - lower), then base + size*acc
	task automatic compute_address(input aeag_entry_t req);
		logic [31:0] lo;
		logic [31:0] extent;
		int          eff_dims;
		int          p;
		elem_addr_t  res;
		if (req.array_id >= MAX_ARRAYS)
			return;
		case (req.op)
			OP_HEADER: begin
				base_mem[req.array_id] = req.value_a;
				size_mem[req.array_id] = req.value_b;
				dims_mem[req.array_id] = req.dim_total;
			end
			OP_BOUNDS: begin
				if (req.dim_pos < MAX_DIMS) begin
					lower_mem[req.array_id][req.dim_pos] = req.value_a;
					upper_mem[req.array_id][req.dim_pos] = req.value_b;
				end
			end
			OP_INDEX: begin
				eff_dims = int'(dims_mem[req.array_id]);
				if (eff_dims == 0)
					eff_dims = 1;
				if (eff_dims > MAX_DIMS)
					eff_dims = MAX_DIMS;
				p = (index_pos >= MAX_DIMS) ? MAX_DIMS - 1 : index_pos;
				lo = lower_mem[req.array_id][p];
				extent = upper_mem[req.array_id][p] - lo + 32'd1;
				horner = horner * extent + (req.value_a - lo);
				if (p + 1 >= eff_dims) begin
					res.address = base_mem[req.array_id] + size_mem[req.array_id] * horner;
					res.ref_array = req.array_id;
					addr_q.push_back(res);
					horner = '0;
					index_pos = 0;
				end else begin
					index_pos = p + 1;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		aeag_entry_t req;
		elem_addr_t  want;
		logic [31:0] got_addr;
		logic [3:0]  got_id;
		if (!arst_n) begin
			horner = '0;
			index_pos = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				req.op        = aeag_op_t'(s_axis_tuser);
				req.array_id  = s_axis_tdata[3:0];
				req.dim_pos   = s_axis_tdata[7:4];
				req.dim_total = s_axis_tdata[11:8];
				req.value_a   = s_axis_tdata[43:12];
				req.value_b   = s_axis_tdata[75:44];
				compute_address(req);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_addr = m_axis_tdata[31:0];
				got_id   = m_axis_tdata[35:32];
				if (addr_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result address=%h ref_array=%0d",
							$realtime, got_addr, got_id);
				end else begin
					want = addr_q.pop_front();
					checked++;
					if (got_addr !== want.address || got_id !== want.ref_array) begin
						errors++;
						if (errors <= 10)
							$display("%0t: mismatch address exp=%h got=%h ref_array exp=%0d got=%0d",
								$realtime, want.address, got_addr, want.ref_array, got_id);
					end
				end
			end
			pending = addr_q.size();
		end
	end

endmodule

[tb/testbench.sv]
// Top of the address generator testbench: clock, reset, request stimulus with bursty
// sender and stalling receiver, and the final verdict.
// Depends on aeag_pkg, array_element_address_generator and address_checker.
`timescale 1ns / 1ps

module testbench;
	import aeag_pkg::*;

	localparam int N_ARR = DEF_MAX_ARRAYS;
	localparam int N_DIM = DEF_MAX_DIMS;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [S_TUSER_W-1:0] s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	int errors;
	int pending;
	int checked;

	// stimulus-side view of what has been written, so no unwritten entry is ever read
	logic        hdr_ok [N_ARR];
	logic        bnd_ok [N_ARR][N_DIM];
	logic [3:0]  dims_sh [N_ARR];
	logic [31:0] lo_sh [N_ARR][N_DIM];
	logic [31:0] hi_sh [N_ARR][N_DIM];
	int          ref_pos;

	int burst_left;
	int n_sent;
	int n_real;
	int n_ignored;
	int n_index;
	int cycles;
	int rx_left;
	int rx_mode;

	array_element_address_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	address_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: stretches of always-ready, random, mostly-stalled and periodic stalls
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		case (rx_mode)
			0: m_axis_tready = 1'b1;
			1: m_axis_tready = 1'($urandom_range(0, 1));
			2: m_axis_tready = ($urandom_range(0, 3) == 0);
			default: m_axis_tready = (rx_left % 5 != 0);
		endcase
	end

	task automatic send(input logic [1:0] cmd, input logic [3:0] id, input logic [3:0] dp,
			input logic [3:0] dt, input logic [31:0] va, input logic [31:0] vb);
		int p;
		int eff;
		if (burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = cmd;
		s_axis_tdata  = {4'b0, vb, va, dt, dp, id};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		n_sent++;
		case (cmd)
			CMD_HEADER: begin
				hdr_ok[id] = 1'b1;
				dims_sh[id] = dt;
				n_real++;
			end
			CMD_BOUNDS: begin
				if (dp < N_DIM) begin
					bnd_ok[id][dp] = 1'b1;
					lo_sh[id][dp] = va;
					hi_sh[id][dp] = vb;
					n_real++;
				end else begin
					n_ignored++;
				end
			end
			CMD_INDEX: begin
				eff = (dims_sh[id] == 0) ? 1 : (dims_sh[id] > N_DIM) ? N_DIM : dims_sh[id];
				p = (ref_pos >= N_DIM) ? N_DIM - 1 : ref_pos;
				ref_pos = (p + 1 >= eff) ? 0 : p + 1;
				n_index++;
				n_real++;
			end
			default: n_ignored++;
		endcase
	endtask

	task automatic write_header(input logic [3:0] id);
		int r;
		logic [3:0] dt;
		logic [31:0] esize;
		r = $urandom_range(0, 99);
		dt = 4'((r < 70) ? $urandom_range(1, 3) : (r < 85) ? $urandom_range(4, 10) :
			$urandom_range(0, 15));
		esize = ($urandom_range(0, 4) != 0) ? (32'd1 << $urandom_range(0, 4)) : $urandom;
		send(CMD_HEADER, id, 4'($urandom), dt, $urandom, esize);
	endtask

	task automatic write_bounds(input logic [3:0] id, input logic [3:0] dp);
		int mode;
		logic [31:0] lo;
		logic [31:0] hi;
		mode = $urandom_range(0, 9);
		lo = $urandom_range(0, 200) - 100;
		if (mode == 0) begin
			lo = $urandom;
			hi = $urandom;
		end else if (mode == 1) begin
			hi = lo - $urandom_range(1, 5);
		end else begin
			hi = lo + $urandom_range(0, 15);
		end
		send(CMD_BOUNDS, id, dp, 4'($urandom), lo, hi);
	endtask

	// one well-formed reference with occasional writes and array switches in between
	task automatic run_reference(input logic [3:0] first_id);
		logic [3:0]  id;
		logic [31:0] extent;
		logic [31:0] idx;
		int          p;
		int          r;
		id = first_id;
		if (!hdr_ok[id])
			write_header(id);
		do begin
			p = (ref_pos >= N_DIM) ? N_DIM - 1 : ref_pos;
			if (!bnd_ok[id][p])
				write_bounds(id, 4'(p));
			extent = hi_sh[id][p] - lo_sh[id][p] + 32'd1;
			if (extent != 0 && extent <= 1024 && $urandom_range(0, 3) != 0)
				idx = lo_sh[id][p] + $urandom_range(0, extent - 1);
			else
				idx = $urandom;
			send(CMD_INDEX, id, 4'($urandom), 4'($urandom), idx, $urandom);
			if (ref_pos != 0) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					write_header(id);
				end else if (r < 8) begin
					write_bounds(id, 4'($urandom_range(0, N_DIM - 1)));
				end else if (r < 12) begin
					id = 4'($urandom);
					if (!hdr_ok[id])
						write_header(id);
				end
			end
		end while (ref_pos != 0);
	endtask

	task automatic drain;
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int r;
		int rnd_start;
		logic paused;
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		burst_left = 0;
		rx_left = 0;
		rx_mode = 0;
		cycles = 0;
		n_sent = 0;
		n_real = 0;
		n_ignored = 0;
		n_index = 0;
		ref_pos = 0;
		paused = 1'b0;
		for (int a = 0; a < N_ARR; a++) begin
			hdr_ok[a] = 1'b0;
			dims_sh[a] = '0;
			for (int d = 0; d < N_DIM; d++) begin
				bnd_ok[a][d] = 1'b0;
				lo_sh[a][d] = '0;
				hi_sh[a][d] = '0;
			end
		end
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// two-dim array with a full-range first dimension (extent wraps to zero)
		send(CMD_HEADER, 4'd0, 4'd0, 4'd2, 32'h0000_1000, 32'd4);
		send(CMD_BOUNDS, 4'd0, 4'd0, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		send(CMD_BOUNDS, 4'd0, 4'd1, 4'd0, 32'hFFFF_FFFE, 32'd5);
		send(CMD_INDEX, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'd0);
		send(CMD_INDEX, 4'd0, 4'd0, 4'd0, 32'd3, 32'd0);
		// zero dimension count, empty extent, extreme base and size
		send(CMD_HEADER, 4'd15, 4'd15, 4'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send(CMD_BOUNDS, 4'd15, 4'd0, 4'd15, 32'd10, 32'd3);
		send(CMD_INDEX, 4'd15, 4'd15, 4'd15, 32'h8000_0000, 32'hFFFF_FFFF);
		// dimension count above the maximum is clamped
		send(CMD_HEADER, 4'd1, 4'd0, 4'd15, 32'h8000_0000, 32'h8000_0000);
		for (int d = 0; d < N_DIM; d++)
			send(CMD_BOUNDS, 4'd1, 4'(d), 4'd0, 32'(-d), 32'(d + 1));
		for (int d = 0; d < N_DIM; d++)
			send(CMD_INDEX, 4'd1, 4'd0, 4'd0, 32'(d), 32'd0);
		// ignored: bound write past the last dimension, unused command
		send(CMD_BOUNDS, 4'd1, 4'd15, 4'd0, 32'hDEAD_BEEF, 32'hDEAD_BEEF);
		send(CMD_UNUSED, 4'd2, 4'd3, 4'd4, $urandom, $urandom);
		// header rewrite in the middle of a reference
		send(CMD_INDEX, 4'd0, 4'd0, 4'd0, 32'd5, 32'd0);
		send(CMD_HEADER, 4'd0, 4'd0, 4'd2, 32'h0000_2000, 32'hFFFF_FFF8);
		send(CMD_INDEX, 4'd0, 4'd0, 4'd0, 32'd4, 32'd0);
		// reference that switches array halfway
		send(CMD_HEADER, 4'd3, 4'd0, 4'd2, 32'h4000_0000, 32'd16);
		send(CMD_BOUNDS, 4'd3, 4'd1, 4'd0, 32'd1, 32'd4);
		send(CMD_INDEX, 4'd0, 4'd0, 4'd0, 32'd1, 32'd0);
		send(CMD_INDEX, 4'd3, 4'd0, 4'd0, 32'd2, 32'd0);
		drain();

		rnd_start = n_real;
		while (n_real - rnd_start < RANDOM_ITEMS) begin
			if (!paused && n_real - rnd_start > RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 62)
				run_reference(4'($urandom));
			else if (r < 72)
				write_header(4'($urandom));
			else if (r < 86)
				write_bounds(4'($urandom), 4'($urandom_range(0, N_DIM - 1)));
			else if (r < 93)
				send(CMD_BOUNDS, 4'($urandom), 4'($urandom_range(N_DIM, 15)), 4'($urandom),
					$urandom, $urandom);
			else
				send(CMD_UNUSED, 4'($urandom), 4'($urandom), 4'($urandom), $urandom,
					$urandom);
		end
		// leave no reference half done
		if (ref_pos != 0)
			run_reference(4'd1);

		drain();
		repeat (20) @(negedge clk);
		$display("tb: %0d requests (%0d index, %0d ignored), %0d addresses checked",
			n_sent, n_index, n_ignored, checked);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/aeag_pkg.sv
hw/rtl/aeag_front.sv
hw/rtl/aeag_queue.sv
hw/rtl/aeag_back.sv
hw/rtl/array_element_address_generator.sv
tb/address_checker.sv
tb/testbench.sv
